// ----- rtl/core/fslf_pkg.sv -----
// Shared types and constants of the fixed-string line filter.
package fslf_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_LINE    = 1024;
  localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
  localparam int PAT_LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int LINE_CNT_W  = $clog2(MAX_LINE);

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  typedef enum logic [1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2,
    REG_INVERT   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic        line_selected;
    logic [31:0] line_number;
    logic [31:0] selected_count;
    logic        stream_done;
  } out_item_t;

  // Control handed from the accept stage to the verdict stage.
  typedef struct packed {
    logic                  searched;
    logic                  line_end;
    logic                  flush;
    logic                  emit;
    logic [LINE_CNT_W-1:0] line_len;
  } stage_ctl_t;

endpackage

// ----- rtl/core/fslf_cell.sv -----
// One window cell: holds a text byte, passes it on, compares it to its pattern byte.
module fslf_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  input  logic       cmp_en,
  output logic [7:0] byte_out,
  output logic       eq_out
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  assign byte_nxt = shift_en ? byte_in : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;
  // cells outside the aligned pattern always agree
  assign eq_out   = !cmp_en || (byte_r == pat_byte);

endmodule

// ----- rtl/core/fixed_string_line_filter.sv -----
// Top level of the fixed-string line filter: config regs, cell chain, verdict stage.
//
// Usage notes
// - in_valid/in_ready carry one transaction per text byte (in_data.text_byte), or a
//   stream-end marker (in_data.stream_end = 1) that flushes any partial line.
// - out_valid/out_ready carry one verdict transaction per finished line: selection,
//   line number, running selected count and a stream_done flag.
// - A line ends on a newline byte (which belongs to the line) or after 1023 bytes.
// - Throughput: one byte per cycle, sustained while the receiver keeps up. The verdict of
//   a line end is held in the verdict stage, then registered on the output.
// - The rate is set by the 16-cell window chain, which shifts once per accepted and
//   searched byte, and by the single verdict stage behind it.
// - When the receiver stalls, the output register holds its verdict and bytes keep
//   flowing through the verdict stage until the next line end (or a stream end that
//   flushes a partial line) reaches it; then in_ready drops until out_ready returns.
// - Reset (rst_n low, synchronous) clears config registers, line state, counters and
//   both pipeline valids. The user must write config over the APB port only while idle (unchecked).
module fixed_string_line_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fslf_pkg::in_item_t            in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output fslf_pkg::out_item_t           out_data,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fslf_pkg::PADDR_W-1:0]  paddr,
  input  logic [fslf_pkg::PDATA_W-1:0]  pwdata,
  output logic [fslf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int MaxPattern = fslf_pkg::MAX_PATTERN;
  localparam int IdxW       = fslf_pkg::PAT_IDX_W;
  localparam int LenW       = fslf_pkg::PAT_LEN_W;
  localparam int CntW       = fslf_pkg::LINE_CNT_W;
  localparam logic [CntW-1:0] LineLimit = CntW'(fslf_pkg::MAX_LINE - 1);
  localparam logic [LenW-1:0] PatFull   = LenW'(MaxPattern);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [63:0]     pat_low_r, pat_low_nxt;
  logic [63:0]     pat_high_r, pat_high_nxt;
  logic [4:0]      pat_len_r, pat_len_nxt;
  logic            invert_r, invert_nxt;
  logic            cfg_wr;
  fslf_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = fslf_pkg::reg_idx_t'(paddr[4:3]);

  always_comb begin
    pat_low_nxt  = pat_low_r;
    pat_high_nxt = pat_high_r;
    pat_len_nxt  = pat_len_r;
    invert_nxt   = invert_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        fslf_pkg::REG_PAT_LOW:  pat_low_nxt  = pwdata;
        fslf_pkg::REG_PAT_HIGH: pat_high_nxt = pwdata;
        fslf_pkg::REG_PAT_LEN:  pat_len_nxt  = pwdata[4:0];
        fslf_pkg::REG_INVERT:   invert_nxt   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fslf_pkg::REG_PAT_LOW:  prdata = pat_low_r;
      fslf_pkg::REG_PAT_HIGH: prdata = pat_high_r;
      fslf_pkg::REG_PAT_LEN:  prdata = {59'd0, pat_len_r};
      fslf_pkg::REG_INVERT:   prdata = {63'd0, invert_r};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
      invert_r   <= 1'b0;
    end else begin
      pat_low_r  <= pat_low_nxt;
      pat_high_r <= pat_high_nxt;
      pat_len_r  <= pat_len_nxt;
      invert_r   <= invert_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Effective pattern, right-aligned onto the cell chain. Registered: the user must only
  // change config while idle (unchecked), so the register lag is never seen by a byte.
  // ---------------------------------------------------------------------------
  logic [7:0]            pat_bytes [MaxPattern];
  logic [LenW-1:0]       len_sat;
  logic [LenW-1:0]       eff_len;
  logic [LenW-1:0]       eff_len_r;
  logic [7:0]            apat_nxt [MaxPattern];
  logic [7:0]            apat_r   [MaxPattern];
  logic [MaxPattern-1:0] amask_nxt, amask_r;

  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      if (i < 8) begin
        pat_bytes[i] = pat_low_r[8*(i%8) +: 8];
      end else begin
        pat_bytes[i] = pat_high_r[8*(i%8) +: 8];
      end
    end
  end

  assign len_sat = (5'(pat_len_r) > 5'(PatFull)) ? PatFull : LenW'(pat_len_r);

  // string is cut at its first zero byte
  always_comb begin
    eff_len = len_sat;
    for (int i = MaxPattern - 1; i >= 0; i--) begin
      if ((LenW'(i) < len_sat) && (pat_bytes[i] == fslf_pkg::ZERO_BYTE)) begin
        eff_len = LenW'(i);
      end
    end
  end

  // cell j compares against pattern byte j + len - MaxPattern
  always_comb begin
    logic [LenW:0] k;
    for (int j = 0; j < MaxPattern; j++) begin
      k            = (LenW + 1)'(j) + (LenW + 1)'(eff_len);
      amask_nxt[j] = (k >= (LenW + 1)'(MaxPattern));
      apat_nxt[j]  = pat_bytes[IdxW'(k - (LenW + 1)'(MaxPattern))];
    end
  end

  always_ff @(posedge clk) begin
    eff_len_r <= eff_len;
    amask_r   <= amask_nxt;
    apat_r    <= apat_nxt;
  end

  // ---------------------------------------------------------------------------
  // Accept stage: line bookkeeping and the window chain
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic [CntW-1:0]   line_len_r, line_len_nxt;
  logic              zero_seen_r, zero_seen_nxt;
  logic [CntW-1:0]   len_inc;
  logic              zero_now;
  logic              searched;
  logic              line_end;
  fslf_pkg::stage_ctl_t acc_ctl;

  assign in_acc   = in_valid && in_ready;
  assign len_inc  = line_len_r + CntW'(1);
  assign zero_now = zero_seen_r || (in_data.text_byte == fslf_pkg::ZERO_BYTE);
  assign searched = !in_data.stream_end && !zero_now;
  assign line_end = !in_data.stream_end &&
                    ((in_data.text_byte == fslf_pkg::NEWLINE_BYTE) || (len_inc >= LineLimit));

  always_comb begin
    acc_ctl.searched = searched;
    acc_ctl.line_end = line_end;
    acc_ctl.flush    = in_data.stream_end;
    acc_ctl.emit     = line_end || (in_data.stream_end && (line_len_r != '0));
    acc_ctl.line_len = len_inc;
  end

  always_comb begin
    line_len_nxt  = line_len_r;
    zero_seen_nxt = zero_seen_r;
    if (in_acc) begin
      if (in_data.stream_end || line_end) begin
        line_len_nxt  = '0;
        zero_seen_nxt = 1'b0;
      end else begin
        line_len_nxt  = len_inc;
        zero_seen_nxt = zero_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r  <= '0;
      zero_seen_r <= 1'b0;
    end else begin
      line_len_r  <= line_len_nxt;
      zero_seen_r <= zero_seen_nxt;
    end
  end

  // Bytes enter at the top cell and move one cell down per searched byte.
  // Stale bytes from older lines are masked by the line length check.
  logic [MaxPattern:0][7:0] chain;
  logic [MaxPattern-1:0]    cell_eq;
  logic                     shift_en;

  assign shift_en          = in_acc && searched;
  assign chain[MaxPattern] = in_data.text_byte;

  for (genvar g = 0; g < MaxPattern; g++) begin : g_cell
    fslf_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .byte_in  (chain[g+1]),
      .pat_byte (apat_r[g]),
      .cmp_en   (amask_r[g]),
      .byte_out (chain[g]),
      .eq_out   (cell_eq[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Verdict stage
  // ---------------------------------------------------------------------------
  logic                 s1_valid_r, s1_valid_nxt;
  fslf_pkg::stage_ctl_t s1_ctl_r;
  logic                 line_hit_r, line_hit_nxt;
  logic [31:0]          line_cnt_r, line_cnt_nxt;
  logic [31:0]          sel_cnt_r, sel_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  fslf_pkg::out_item_t  out_data_r, out_data_nxt;
  logic                 out_free;
  logic                 s1_move;
  logic                 win_hit;
  logic                 hit;
  logic                 sel;
  logic [31:0]          line_num;
  logic [31:0]          sel_num;

  assign out_free = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && (out_free || !s1_ctl_r.emit);
  assign in_ready = !s1_valid_r || s1_move;

  assign win_hit  = s1_ctl_r.searched && (eff_len_r != '0) &&
                    (s1_ctl_r.line_len >= CntW'(eff_len_r)) && (&cell_eq);
  assign hit      = line_hit_r || win_hit || (eff_len_r == '0);
  assign sel      = hit != invert_r;
  assign line_num = (line_cnt_r == '1) ? line_cnt_r : line_cnt_r + 32'd1;
  assign sel_num  = (sel && (sel_cnt_r != '1)) ? sel_cnt_r + 32'd1 : sel_cnt_r;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    line_hit_nxt  = line_hit_r;
    line_cnt_nxt  = line_cnt_r;
    sel_cnt_nxt   = sel_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_move) begin
      s1_valid_nxt = 1'b0;
      if (s1_ctl_r.emit) begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.line_selected = sel;
        out_data_nxt.line_number   = line_num;
        out_data_nxt.selected_count = sel_num;
        out_data_nxt.stream_done   = s1_ctl_r.flush;
        line_cnt_nxt               = line_num;
        sel_cnt_nxt                = sel_num;
      end
      if (s1_ctl_r.emit || s1_ctl_r.flush) begin
        line_hit_nxt = 1'b0;
      end else begin
        line_hit_nxt = line_hit_r || win_hit;
      end
      if (s1_ctl_r.flush) begin
        line_cnt_nxt = '0;
        sel_cnt_nxt  = '0;
      end
    end

    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      line_hit_r  <= 1'b0;
      line_cnt_r  <= '0;
      sel_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      line_hit_r  <= line_hit_nxt;
      line_cnt_r  <= line_cnt_nxt;
      sel_cnt_r   <= sel_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r <= acc_ctl;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
